[src/open_address_hash_table_unit_assert.svh]
// Assertion macros shared by the checker of the hash table unit.
// Depends on nothing; include with the bare file name.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define OAHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/oaht_pkg.sv]
// Shared types and constants of the open-address hash table unit.
// Depends on nothing.
package oaht_pkg;
  localparam int KeyW   = 16;
  localparam int ValW   = 16;
  localparam int Depth  = 64;
  localparam int AddrW  = 6;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_INSERTED = 3'd2,
    ST_DUP      = 3'd3,
    ST_REBUILT  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  function automatic logic [5:0] prime_of(input logic [1:0] s);
    case (s)
      2'd0:    prime_of = 6'd11;
      2'd1:    prime_of = 6'd19;
      2'd2:    prime_of = 6'd29;
      default: prime_of = 6'd37;
    endcase
  endfunction
endpackage

[src/oaht_ram.sv]
// Generic single-port-write, one-read synchronous RAM with registered read data.
// Depends on nothing.
module oaht_ram #(
  parameter int W = 32,
  parameter int N = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [N];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/oaht_modp.sv]
// Iterative reduction of a key modulo the current prime, one bit per cycle.
// Depends on oaht_pkg.
module oaht_modp
  import oaht_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [KeyW-1:0] key,
  input  logic [5:0]      m,
  output logic            done,
  output logic [5:0]      rem
);
  logic [KeyW-1:0] sh_r;
  logic [6:0]      rem_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic [6:0]      t;

  assign t    = {rem_r[5:0], sh_r[KeyW-1]};
  assign done = busy_r && (cnt_r == 5'd0);
  assign rem  = rem_r[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      sh_r   <= key;
      rem_r  <= '0;
      cnt_r  <= 5'(KeyW);
    end else if (busy_r && cnt_r != 5'd0) begin
      sh_r  <= {sh_r[KeyW-2:0], 1'b0};
      rem_r <= (t >= {1'b0, m}) ? t - {1'b0, m} : t;
      cnt_r <= cnt_r - 5'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end
endmodule

[src/open_address_hash_table_unit.sv]
// Top level of the open-address hash table unit: controller and memories.
// Depends on oaht_pkg, oaht_ram and oaht_modp.
//
// Usage: the in_ channel takes one word per request (find or insert of a
// key with a value); the out_ channel returns exactly one word per request
// with status, slot, stored value and the collision count of the probe.
// One request is worked at a time. A request runs the bit-serial key modulo
// prime, then a read and a check of the key/value memory per probed slot
// (registered read), then a step to post the word. A word with key zero is
// answered at once and shows out_valid in the cycle after it is accepted.
// A rebuild copies every live entry to a buffer memory, clears the table
// and reinserts each entry with its own modulo and probe walk; when no size
// fits, each buffered entry is written back to its old slot. The memory
// read port sets the pace.
// After reset a clearing pass writes every entry of the key memory to empty,
// during which in_ready stays low.
// A finished word is held in an output register; while out_ready is low the
// unit waits with that word and takes no new request.
module open_address_hash_table_unit
  import oaht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_key,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [15:0] out_found_value,
  output logic [5:0]  out_probe_count
);
  typedef enum logic [13:0] {
    S_CLR    = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_MOD    = 14'b00000000000100,
    S_RD     = 14'b00000000001000,
    S_CHK    = 14'b00000000010000,
    S_OUT    = 14'b00000000100000,
    S_CPRD   = 14'b00000001000000,
    S_CPCHK  = 14'b00000010000000,
    S_TRY    = 14'b00000100000000,
    S_WIPE   = 14'b00001000000000,
    S_BRD    = 14'b00010000000000,
    S_BCHK   = 14'b00100000000000,
    S_RMOD   = 14'b01000000000000,
    S_COMMIT = 14'b10000000000000
  } state_t;

  // Two regions of the memory: the live table at base 0 and a scratch table
  // at base 37 would not fit 64 entries; instead rebuild writes scratch into
  // the live region only after the buffer holds every entry, and a failed
  // attempt re-wipes. A failed final attempt puts every buffered entry back
  // at the slot it came from, which the buffer keeps beside the entry.
  state_t state_r;
  logic [1:0]  step_r, try_r;
  logic [5:0]  m_r, p_r, c_r, i_r, n_r, cnt_r;
  logic [5:0]  home;
  logic        req_r, restore_r;
  logic [15:0] key_r, val_r;
  logic [2:0]  st_r;
  logic [5:0]  slot_r, pc_r;
  logic [15:0] fv_r;
  logic        ov_r;

  logic        kv_we;
  logic [5:0]  kv_wa, kv_ra;
  logic [31:0] kv_wd, kv_rd;
  logic        bf_we;
  logic [5:0]  bf_wa, bf_ra;
  logic [37:0] bf_wd, bf_rd;
  logic        mstart, mdone;
  logic [15:0] mkey;
  logic [6:0]  np;

  oaht_ram #(.W(32), .N(Depth), .AW(AddrW)) u_kv (
    .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_wd), .raddr(kv_ra), .rdata(kv_rd));
  oaht_ram #(.W(38), .N(Depth), .AW(AddrW)) u_buf (
    .clk(clk), .we(bf_we), .waddr(bf_wa), .wdata(bf_wd), .raddr(bf_ra), .rdata(bf_rd));
  oaht_modp u_mod (
    .clk(clk), .rst_n(rst_n), .start(mstart), .key(mkey), .m(m_r),
    .done(mdone), .rem(home));

  assign in_ready        = (state_r == S_IDLE) && !ov_r;
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_slot        = slot_r;
  assign out_found_value = fv_r;
  assign out_probe_count = pc_r;

  // Next probe position (p + c) mod m, with c already incremented; both < m.
  logic [5:0] c1;
  assign c1 = c_r + 6'd1;
  assign np = {1'b0, p_r} + {1'b0, c1};

  logic [15:0] rk;
  assign rk = kv_rd[31:16];

  always_comb begin
    kv_we = 1'b0; kv_wa = p_r; kv_wd = {key_r, val_r}; kv_ra = p_r;
    bf_we = 1'b0; bf_wa = n_r; bf_wd = {i_r, kv_rd}; bf_ra = i_r;
    mstart = 1'b0; mkey = key_r;
    unique case (state_r)
      S_CLR:    begin kv_we = 1'b1; kv_wa = i_r; kv_wd = '0; end
      S_IDLE:   begin mkey = in_key; mstart = in_valid && !ov_r && in_key != 16'd0; end
      S_CPRD:   kv_ra = i_r;
      S_CPCHK:  bf_we = (rk != 16'd0);
      S_WIPE:   begin kv_we = 1'b1; kv_wa = i_r; kv_wd = '0; end
      S_RMOD:   begin
        mkey = bf_rd[31:16]; mstart = (cnt_r == 6'd1) && !restore_r;
        // When restoring, the buffered entry goes straight back to its slot.
        kv_we = restore_r && (cnt_r == 6'd1); kv_wa = bf_rd[37:32]; kv_wd = bf_rd[31:0];
      end
      S_BCHK:   begin kv_we = (rk == 16'd0) && (c_r < (m_r >> 1)); kv_wd = {key_r, val_r}; end
      S_CHK:    begin
        kv_we = req_r && rk == 16'd0 && c_r < (m_r >> 1);
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r <= '0; step_r <= '0; m_r <= 6'd11; ov_r <= 1'b0; cnt_r <= '0;
      restore_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          i_r <= i_r + 6'd1;
          if (i_r == 6'(Depth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && !ov_r) begin
          req_r <= in_req_type; key_r <= in_key; val_r <= in_value;
          c_r <= '0; fv_r <= '0; slot_r <= '0; pc_r <= '0;
          if (in_key == 16'd0) begin
            st_r <= in_req_type ? ST_DUP : ST_NOTFOUND;
            ov_r <= 1'b1;
          end else state_r <= S_MOD;
        end
        S_MOD: if (mdone) begin p_r <= home; state_r <= S_RD; end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (rk == key_r) begin
            st_r <= req_r ? ST_DUP : ST_FOUND; slot_r <= p_r; pc_r <= c_r;
            fv_r <= req_r ? 16'd0 : kv_rd[15:0]; state_r <= S_OUT;
          end else if (rk == 16'd0 || c1 >= m_r) begin
            pc_r <= (rk == 16'd0) ? c_r : c1;
            if (!req_r) begin st_r <= ST_NOTFOUND; state_r <= S_OUT; end
            else if (rk == 16'd0 && c_r < (m_r >> 1)) begin
              st_r <= ST_INSERTED; slot_r <= p_r; state_r <= S_OUT;
            end else begin
              i_r <= '0; n_r <= '0; state_r <= S_CPRD;
            end
          end else begin
            c_r <= c1;
            p_r <= (np >= {1'b0, m_r}) ? 6'(np - {1'b0, m_r}) : np[5:0];
            state_r <= S_RD;
          end
        end
        S_CPRD: state_r <= S_CPCHK;
        S_CPCHK: begin
          if (rk != 16'd0) n_r <= n_r + 6'd1;
          if (i_r == m_r - 6'd1) begin
            try_r <= step_r; restore_r <= 1'b0; state_r <= S_TRY;
          end else begin i_r <= i_r + 6'd1; state_r <= S_CPRD; end
        end
        S_TRY: begin
          if (try_r == 2'd3) begin
            // No larger size fits: put the old table back.
            try_r <= step_r; restore_r <= 1'b1;
            m_r <= prime_of(step_r);
          end else begin
            try_r <= try_r + 2'd1; m_r <= prime_of(try_r + 2'd1);
          end
          i_r <= '0; state_r <= S_WIPE;
        end
        S_WIPE: begin
          if (i_r == 6'd36) begin i_r <= '0; cnt_r <= '0; state_r <= S_RMOD; end
          else i_r <= i_r + 6'd1;
        end
        S_RMOD: begin
          // Buffer read settles, then the modulo runs on the buffered key.
          if (i_r == n_r) state_r <= S_COMMIT;
          else if (restore_r) begin
            if (cnt_r == 6'd1) begin i_r <= i_r + 6'd1; cnt_r <= '0; end
            else cnt_r <= cnt_r + 6'd1;
          end else begin
            if (cnt_r < 6'd2) cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd1) begin key_r <= bf_rd[31:16]; val_r <= bf_rd[15:0]; end
            if (mdone) begin p_r <= home; c_r <= '0; state_r <= S_BRD; end
          end
        end
        S_BRD: state_r <= S_BCHK;
        S_BCHK: begin
          if (rk == 16'd0 && c_r < (m_r >> 1)) begin
            i_r <= i_r + 6'd1; cnt_r <= '0; state_r <= S_RMOD;
          end else if (rk == 16'd0 || c1 >= m_r || c1 >= (m_r >> 1)) begin
            if (restore_r) state_r <= S_COMMIT;
            else state_r <= S_TRY;
          end else begin
            c_r <= c1;
            p_r <= (np >= {1'b0, m_r}) ? 6'(np - {1'b0, m_r}) : np[5:0];
            state_r <= S_BRD;
          end
        end
        S_COMMIT: begin
          if (restore_r) st_r <= ST_FULL;
          else begin st_r <= ST_REBUILT; step_r <= try_r; end
          state_r <= S_OUT;
        end
        S_OUT: begin ov_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_CLR;
      endcase
    end
  end
endmodule

[src/oaht_checker.sv]
// Port-level checker of the hash table unit, bound to the top level.
// Depends on open_address_hash_table_unit_assert.svh.
`include "open_address_hash_table_unit_assert.svh"
module oaht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [5:0] out_slot
);
  `OAHT_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `OAHT_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `OAHT_ASSERT_IMP(a_code, clk, rst_n, out_valid, out_status <= 3'd5)
  `OAHT_ASSERT_IMP(a_slot, clk, rst_n, out_valid, out_slot <= 6'd36)
endmodule

bind open_address_hash_table_unit oaht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_slot(out_slot));
